// ===== hw/rtl/frd_pkg.sv =====
// shared types and constants of the flood relay decision unit
`timescale 1ns / 1ps

package frd_pkg;

    // history depth default and request queue depth
    localparam int HISTORY_DEPTH_DEF = 40;
    localparam int QUEUE_DEPTH       = 2;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TIME = 1'b1;
    localparam logic [7:0]  OWN_NODE_RST  = 8'd0;
    localparam logic [15:0] SLOT_TIME_RST = 16'd28;

    // admission limits
    localparam logic [7:0] MIN_LENGTH = 8'd16;

    // snr steps where the contention window doubles (window 2^3 below the first)
    localparam logic signed [12:0] SNR_STEP_CW4 = -13'sd1400;
    localparam logic signed [12:0] SNR_STEP_CW5 = -13'sd800;
    localparam logic signed [12:0] SNR_STEP_CW6 = -13'sd200;
    localparam logic signed [12:0] SNR_STEP_CW7 = 13'sd400;
    localparam logic signed [12:0] SNR_STEP_CW8 = 13'sd1000;

    typedef enum logic [2:0] {
        V_FORWARD    = 3'd0,
        V_BAD_LENGTH = 3'd1,
        V_RX_ERROR   = 3'd2,
        V_HOP_ZERO   = 3'd3,
        V_DUPLICATE  = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DECIDE,
        BK_EMIT
    } t_back_state;

    // classified request travelling from front to back
    typedef struct packed {
        logic [31:0] source_node;
        logic [31:0] packet_id;
        logic [7:0]  new_flags;
        logic [7:0]  slots;
        t_verdict    verdict;
    } t_frd_item;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_frd_qstat;

endpackage

// ===== hw/rtl/flood_relay_decision_unit.sv =====
// top level of the flood relay decision unit
`timescale 1ns / 1ps

// Decides for each received packet header whether a flooding repeater
// rebroadcasts it. A request is taken when start is high and busy is low; its
// result appears for exactly one cycle with o_result_strobe and must be taken
// then, since the receiver cannot stall the block. A dropped request (short,
// receive error, hop limit zero) gives its result in the cycle right after it
// leaves the two-entry queue; a request that passes those checks is compared against
// every history entry through the history ram's single registered read port,
// and that scan sets the sustained rate. The front end keeps taking requests
// until the queue and its holding stage are full. The history starts empty
// after reset with no clearing pass; configuration is to be written while idle,
// which the block itself does not enforce.

module flood_relay_decision_unit #(
    parameter int HISTORY_DEPTH = frd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [31:0]                       i_source_node,
    input  logic [31:0]                       i_packet_id,
    input  logic [7:0]                        i_flag_byte,
    input  logic [7:0]                        i_packet_length,
    input  logic                              i_receive_ok,
    input  logic signed [12:0]                i_snr_centi_db,
    input  logic [7:0]                        i_random_draw,
    input  logic                              i_cfg_we,
    input  logic [frd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [frd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_result_strobe,
    output logic [2:0]                        o_verdict,
    output logic [7:0]                        o_new_flag_byte,
    output logic [7:0]                        o_relay_byte,
    output logic [23:0]                       o_backoff_ms
);
    import frd_pkg::*;

    logic        r_own_node_byte;
    logic [7:0]  r_own_node;
    logic [15:0] r_slot_time_ms;

    t_frd_qstat  qstat;
    t_frd_item   front_item;
    t_frd_item   queue_item;
    logic        push;
    logic        pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_node     <= OWN_NODE_RST;
            r_slot_time_ms <= SLOT_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_NODE:  r_own_node     <= i_cfg_data[7:0];
                CFG_SLOT_TIME: r_slot_time_ms <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // marks a write to the node byte register, for debug visibility only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_node_byte <= 1'b0;
        end else if (i_cfg_we && i_cfg_index == CFG_OWN_NODE) begin
            r_own_node_byte <= 1'b1;
        end
    end

    // front end
    frd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_source_node   (i_source_node),
        .i_packet_id     (i_packet_id),
        .i_flag_byte     (i_flag_byte),
        .i_packet_length (i_packet_length),
        .i_receive_ok    (i_receive_ok),
        .i_snr_centi_db  (i_snr_centi_db),
        .i_random_draw   (i_random_draw),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_item          (front_item)
    );

    // request queue
    frd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_qstat (qstat)
    );

    // back end
    frd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (qstat),
        .i_item          (queue_item),
        .o_pop           (pop),
        .i_own_node_byte (r_own_node),
        .i_slot_time_ms  (r_slot_time_ms),
        .o_result_strobe (o_result_strobe),
        .o_verdict       (o_verdict),
        .o_new_flag_byte (o_new_flag_byte),
        .o_relay_byte    (o_relay_byte),
        .o_backoff_ms    (o_backoff_ms)
    );

    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_OWN_NODE) |=> r_own_node_byte)
        else $error("node byte write not recorded");

endmodule

// ===== hw/rtl/frd_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module frd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 40,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/frd_front.sv =====
// front end: takes a request and classifies it ahead of the history check
`timescale 1ns / 1ps

module frd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [31:0]            i_source_node,
    input  logic [31:0]            i_packet_id,
    input  logic [7:0]             i_flag_byte,
    input  logic [7:0]             i_packet_length,
    input  logic                   i_receive_ok,
    input  logic signed [12:0]     i_snr_centi_db,
    input  logic [7:0]             i_random_draw,
    input  frd_pkg::t_frd_qstat    i_qstat,
    output logic                   o_push,
    output frd_pkg::t_frd_item     o_item
);
    import frd_pkg::*;

    logic      r_valid;
    t_frd_item r_item;
    t_frd_item n_item;
    logic      accept;
    logic [2:0] hops;
    logic [7:0] cw_mask;

    // hand the held request over as soon as the queue has room
    assign o_push = r_valid && !i_qstat.full;
    assign busy   = r_valid && !o_push;
    assign accept = start && !busy;
    assign o_item = r_item;

    // classification of the incoming request
    always_comb begin
        hops = i_flag_byte[2:0];
        cw_mask = {i_snr_centi_db >= SNR_STEP_CW8,
                   i_snr_centi_db >= SNR_STEP_CW7,
                   i_snr_centi_db >= SNR_STEP_CW6,
                   i_snr_centi_db >= SNR_STEP_CW5,
                   i_snr_centi_db >= SNR_STEP_CW4,
                   3'b111};
        n_item.source_node = i_source_node;
        n_item.packet_id   = i_packet_id;
        n_item.new_flags   = {i_flag_byte[7:3], hops - 3'd1};
        n_item.slots       = i_random_draw & cw_mask;
        if (i_packet_length < MIN_LENGTH) begin
            n_item.verdict = V_BAD_LENGTH;
        end else if (!i_receive_ok) begin
            n_item.verdict = V_RX_ERROR;
        end else if (hops == 3'd0) begin
            n_item.verdict = V_HOP_ZERO;
        end else begin
            n_item.verdict = V_FORWARD;
        end
    end

    // holding stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // holding stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hw/rtl/frd_queue.sv =====
// short fifo of classified requests between front and back
`timescale 1ns / 1ps

module frd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  frd_pkg::t_frd_item     i_item,
    input  logic                   i_pop,
    output frd_pkg::t_frd_item     o_item,
    output frd_pkg::t_frd_qstat    o_qstat
);
    import frd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    t_frd_item      r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    assign o_qstat.full  = (r_count == CNT_FULL);
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // no overflow and no underflow
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_qstat.full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/frd_back.sv =====
// back end: duplicate scan over the history ring, history update and result
`timescale 1ns / 1ps

module frd_back #(
    parameter int HISTORY_DEPTH = frd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  frd_pkg::t_frd_qstat    i_qstat,
    input  frd_pkg::t_frd_item     i_item,
    output logic                   o_pop,
    input  logic [7:0]             i_own_node_byte,
    input  logic [15:0]            i_slot_time_ms,
    output logic                   o_result_strobe,
    output logic [2:0]             o_verdict,
    output logic [7:0]             o_new_flag_byte,
    output logic [7:0]             o_relay_byte,
    output logic [23:0]            o_backoff_ms
);
    import frd_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);

    t_back_state    r_state;
    t_back_state    n_state;
    t_frd_item      r_item;
    t_verdict       r_verdict;
    logic [23:0]    r_backoff;
    logic [AW-1:0]  r_idx;
    logic           r_issue;
    logic           r_chk_valid;
    logic [AW-1:0]  r_chk_idx;
    logic           r_hit;
    logic [AW-1:0]  r_wslot;
    logic           r_valid_bits [HISTORY_DEPTH];

    logic           ram_we;
    logic [63:0]    ram_rdata;
    logic           cur_match;
    logic           scan_last;
    logic           fwd;

    // history of (source, id) pairs
    frd_ram #(
        .WIDTH (64),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata ({r_item.source_node, r_item.packet_id}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // compare of the registered read data, at the address held in r_chk_idx
    assign cur_match = r_chk_valid && r_valid_bits[r_chk_idx] &&
                       (ram_rdata == {r_item.source_node, r_item.packet_id});
    assign scan_last = r_chk_valid && (r_chk_idx == LAST);
    assign fwd       = (r_verdict == V_FORWARD);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = (i_item.verdict == V_FORWARD) ? BK_SCAN : BK_EMIT;
                end
            end
            BK_SCAN: begin
                if (scan_last) begin
                    n_state = BK_DECIDE;
                end
            end
            BK_DECIDE: n_state = BK_EMIT;
            BK_EMIT:   n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop           = (r_state == BK_IDLE) && !i_qstat.empty;
        ram_we          = (r_state == BK_DECIDE) && !r_hit;
        o_result_strobe = (r_state == BK_EMIT);
        o_verdict       = r_verdict;
        o_new_flag_byte = fwd ? r_item.new_flags : 8'd0;
        o_relay_byte    = fwd ? i_own_node_byte : 8'd0;
        o_backoff_ms    = r_backoff;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_issue     <= 1'b0;
            r_chk_valid <= 1'b0;
            r_wslot     <= '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_valid_bits[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_issue <= (i_item.verdict == V_FORWARD);
            end else if (r_issue && (r_idx == LAST)) begin
                r_issue <= 1'b0;
            end
            r_chk_valid <= r_issue;
            if (ram_we) begin
                r_valid_bits[r_wslot] <= 1'b1;
                r_wslot <= (r_wslot == LAST) ? '0 : r_wslot + 1'b1;
            end
        end
    end

    // request payload, scan address and result fields
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
        if (o_pop) begin
            r_item    <= i_item;
            r_verdict <= i_item.verdict;
            r_backoff <= 24'd0;
            r_hit     <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (r_issue && (r_idx != LAST)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (cur_match) begin
                r_hit <= 1'b1;
            end
            if (r_state == BK_DECIDE) begin
                if (r_hit) begin
                    r_verdict <= V_DUPLICATE;
                end else begin
                    r_backoff <= 24'(r_item.slots) * 24'(i_slot_time_ms);
                end
            end
        end
    end

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe longer than one cycle");

    a_pop_leads_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BK_SCAN || r_state == BK_EMIT))
        else $error("popped request not taken up");

    a_scan_only_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SCAN) |-> (r_item.verdict == V_FORWARD))
        else $error("history scanned for a dropped request");

    a_no_write_on_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_verdict == V_DUPLICATE) |-> !$past(ram_we))
        else $error("duplicate written into history");

endmodule

// ===== tb/flood_relay_decision_unit_tb.sv =====
// self-checking testbench of the flood relay decision unit
`timescale 1ns / 1ps

module flood_relay_decision_unit_tb;
    import frd_pkg::*;

    localparam int HIST_DEPTH   = HISTORY_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_CYCLE = 4;
    localparam int DRAIN_CYCLES = 100;

    // one packet header request with a flag to drain the block before it goes
    typedef struct {
        logic [31:0]        src;
        logic [31:0]        pid;
        logic [7:0]         flags;
        logic [7:0]         len;
        logic               ok;
        logic signed [12:0] snr;
        logic [7:0]         draw;
        bit                 hold;
    } t_pkt_req;

    typedef struct {
        t_verdict    verdict;
        logic [7:0]  flags;
        logic [7:0]  relay;
        logic [23:0] backoff;
    } t_relay_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [31:0]           i_source_node = '0;
    logic [31:0]           i_packet_id = '0;
    logic [7:0]            i_flag_byte = '0;
    logic [7:0]            i_packet_length = '0;
    logic                  i_receive_ok = 1'b0;
    logic signed [12:0]    i_snr_centi_db = '0;
    logic [7:0]            i_random_draw = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_result_strobe;
    logic [2:0]            o_verdict;
    logic [7:0]            o_new_flag_byte;
    logic [7:0]            o_relay_byte;
    logic [23:0]           o_backoff_ms;

    flood_relay_decision_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_source_node   (i_source_node),
        .i_packet_id     (i_packet_id),
        .i_flag_byte     (i_flag_byte),
        .i_packet_length (i_packet_length),
        .i_receive_ok    (i_receive_ok),
        .i_snr_centi_db  (i_snr_centi_db),
        .i_random_draw   (i_random_draw),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_verdict       (o_verdict),
        .o_new_flag_byte (o_new_flag_byte),
        .o_relay_byte    (o_relay_byte),
        .o_backoff_ms    (o_backoff_ms)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the history ring and the registers
    logic [31:0] seen_src_m [HIST_DEPTH];
    logic [31:0] seen_pid_m [HIST_DEPTH];
    bit          seen_ok_m  [HIST_DEPTH];
    int          ring_wr = 0;
    logic [7:0]  own_node_m = OWN_NODE_RST;
    logic [15:0] slot_time_m = SLOT_TIME_RST;

    t_pkt_req      pend_q[$];
    t_relay_result relay_expect_q[$];
    logic [31:0]   recent_src[$];
    logic [31:0]   recent_pid[$];
    t_pkt_req      cur_req;
    int unsigned   n_accepted = 0;
    int unsigned   n_results = 0;
    int unsigned   n_errors = 0;
    int unsigned   cycle_count = 0;
    int            gap_left = 0;
    bit            burst_mode = 0;

    initial begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            seen_src_m[k] = '0;
            seen_pid_m[k] = '0;
            seen_ok_m[k]  = 0;
        end
    end

    // forwarding decision for one accepted request, history updated on forward
    task automatic decide_relay(input t_pkt_req r);
        t_relay_result res;
        bit            hit;
        int            snr_v;
        int            cw;
        logic [7:0]    slots;
        hit = 0;
        res.verdict = V_FORWARD;
        res.flags = '0;
        res.relay = '0;
        res.backoff = '0;
        for (int k = 0; k < HIST_DEPTH; k++)
            if (seen_ok_m[k] && seen_src_m[k] == r.src && seen_pid_m[k] == r.pid)
                hit = 1;
        if (r.len < MIN_LENGTH)
            res.verdict = V_BAD_LENGTH;
        else if (!r.ok)
            res.verdict = V_RX_ERROR;
        else if (r.flags[2:0] == 3'd0)
            res.verdict = V_HOP_ZERO;
        else if (hit)
            res.verdict = V_DUPLICATE;
        if (res.verdict == V_FORWARD) begin
            seen_src_m[ring_wr] = r.src;
            seen_pid_m[ring_wr] = r.pid;
            seen_ok_m[ring_wr]  = 1;
            ring_wr = (ring_wr == HIST_DEPTH - 1) ? 0 : ring_wr + 1;
            // window exponent from snr, division truncates toward zero
            snr_v = int'(r.snr);
            cw = (snr_v + 2000) * 5 / 3000 + 3;
            if (cw < 3)
                cw = 3;
            if (cw > 8)
                cw = 8;
            slots = r.draw & 8'((1 << cw) - 1);
            res.flags = {r.flags[7:3], r.flags[2:0] - 3'd1};
            res.relay = own_node_m;
            res.backoff = 24'(32'(slots) * 32'(slot_time_m));
        end
        relay_expect_q.push_back(res);
    endtask

    // sender gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(40, 120);
    endfunction

    // request driver
    always @(posedge i_clk) begin : req_driver
        int unsigned taken;
        taken = n_accepted;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                decide_relay(cur_req);
                taken = taken + 1;
                n_accepted <= taken;
                gap_left = pick_gap();
            end
            if (start && busy) begin
                // request held until the block takes it
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (pend_q.size() != 0 && !(pend_q[0].hold && n_results != taken)) begin
                cur_req = pend_q.pop_front();
                start           <= 1'b1;
                i_source_node   <= cur_req.src;
                i_packet_id     <= cur_req.pid;
                i_flag_byte     <= cur_req.flags;
                i_packet_length <= cur_req.len;
                i_receive_ok    <= cur_req.ok;
                i_snr_centi_db  <= cur_req.snr;
                i_random_draw   <= cur_req.draw;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_relay_result want;
        if (i_rst_n && o_result_strobe) begin
            if (n_results >= n_accepted) begin
                $display("%0t: unexpected result verdict %0d flags %h relay %h backoff %0d",
                         $time, o_verdict, o_new_flag_byte, o_relay_byte, o_backoff_ms);
                n_errors++;
            end else begin
                want = relay_expect_q.pop_front();
                n_results <= n_results + 1;
                if (o_verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, want.verdict, o_verdict);
                    n_errors++;
                end
                if (o_new_flag_byte !== want.flags) begin
                    $display("%0t: new_flag_byte expected %h actual %h",
                             $time, want.flags, o_new_flag_byte);
                    n_errors++;
                end
                if (o_relay_byte !== want.relay) begin
                    $display("%0t: relay_byte expected %h actual %h",
                             $time, want.relay, o_relay_byte);
                    n_errors++;
                end
                if (o_backoff_ms !== want.backoff) begin
                    $display("%0t: backoff_ms expected %0d actual %0d",
                             $time, want.backoff, o_backoff_ms);
                    n_errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_pkt_req mk_req(input logic [31:0] src, input logic [31:0] pid,
                                        input logic [7:0] flags, input logic [7:0] len,
                                        input logic ok, input int snr,
                                        input logic [7:0] draw, input bit hold);
        t_pkt_req r;
        r.src = src;
        r.pid = pid;
        r.flags = flags;
        r.len = len;
        r.ok = ok;
        r.snr = 13'(snr);
        r.draw = draw;
        r.hold = hold;
        return r;
    endfunction

    // random requests, many reusing recent pairs so duplicates and ring aging show up
    task automatic add_random(input int count);
        t_pkt_req r;
        int       pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 && recent_src.size() != 0) begin
                pick = $urandom_range(0, recent_src.size() - 1);
                r.src = recent_src[pick];
                r.pid = recent_pid[pick];
            end else if (pick < 40) begin
                r.src = $urandom_range(0, 3);
                r.pid = $urandom_range(0, 3);
            end else begin
                r.src = $urandom;
                r.pid = $urandom;
            end
            recent_src.push_back(r.src);
            recent_pid.push_back(r.pid);
            if (recent_src.size() > 64) begin
                void'(recent_src.pop_front());
                void'(recent_pid.pop_front());
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
                r.len = $urandom_range(0, 15);
            else if (pick < 15)
                r.len = MIN_LENGTH;
            else
                r.len = $urandom_range(16, 255);
            r.ok = ($urandom_range(0, 99) >= 8);
            r.flags = $urandom_range(0, 255);
            if ($urandom_range(0, 99) < 15)
                r.snr = 13'($urandom);
            else
                r.snr = 13'(int'($urandom_range(0, 6400)) - 3200);
            r.draw = $urandom_range(0, 255);
            r.hold = ($urandom_range(0, 99) < 3);
            pend_q.push_back(r);
        end
    endtask

    // checked away from the active edge so driver and monitor updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pend_q.size() != 0 || start || n_results != n_accepted);
        repeat (SETTLE_CYCLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OWN_NODE)
            own_node_m = val[7:0];
        else
            slot_time_m = val;
    endtask

    task automatic run_phase(input logic [15:0] own_val, input logic [15:0] slot_val,
                             input int count, input bit bursty);
        wait_idle();
        write_reg(CFG_OWN_NODE, own_val);
        write_reg(CFG_SLOT_TIME, slot_val);
        burst_mode = bursty;
        @(negedge i_clk);
        add_random(count);
    endtask

    // stimulus sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero pair against an empty history, check order, snr steps
        pend_q.push_back(mk_req(32'h0, 32'h0, 8'h01, 8'd16, 1'b1, -4096, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h0, 32'h0, 8'h01, 8'd16, 1'b1, 0, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h1, 32'h1, 8'h00, 8'd15, 1'b0, 0, 8'h00, 0));
        pend_q.push_back(mk_req(32'h1, 32'h2, 8'h07, 8'd0, 1'b1, 0, 8'h00, 0));
        pend_q.push_back(mk_req(32'h1, 32'h3, 8'h00, 8'd255, 1'b0, 0, 8'h00, 0));
        pend_q.push_back(mk_req(32'h1, 32'h4, 8'hF8, 8'd16, 1'b1, 0, 8'h00, 0));
        pend_q.push_back(mk_req(32'h0, 32'h0, 8'h08, 8'd200, 1'b1, 0, 8'h00, 0));
        pend_q.push_back(mk_req(32'h0, 32'h0, 8'h01, 8'd15, 1'b1, 0, 8'h00, 0));
        pend_q.push_back(mk_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'd255, 1'b1,
                                4095, 8'hFF, 0));
        pend_q.push_back(mk_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h07, 8'd100, 1'b1,
                                0, 8'h00, 1));
        pend_q.push_back(mk_req(32'h2, 32'h0, 8'hA1, 8'd64, 1'b1, -3200, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h1, 8'h52, 8'd64, 1'b1, -1401, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h2, 8'h33, 8'd64, 1'b1, -1400, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h3, 8'hC4, 8'd64, 1'b1, -800, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h4, 8'h15, 8'd64, 1'b1, -201, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h5, 8'hE6, 8'd64, 1'b1, -200, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h6, 8'h77, 8'd64, 1'b1, 400, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h7, 8'h02, 8'd64, 1'b1, 999, 8'hFF, 0));
        pend_q.push_back(mk_req(32'h2, 32'h8, 8'h9B, 8'd64, 1'b1, 1000, 8'hAA, 0));
        pend_q.push_back(mk_req(32'h2, 32'h9, 8'h4C, 8'd64, 1'b1, 3200, 8'h55, 0));

        // random phases over several register settings, extremes included
        run_phase(16'hFFFF, 16'hFFFF, 70, 0);
        run_phase(16'hFF00, 16'h0000, 70, 1);
        run_phase(16'($urandom), 16'd1, 70, 0);
        run_phase(16'($urandom), 16'($urandom), 70, 0);
        run_phase(16'h005A, SLOT_TIME_RST, 70, 1);
        run_phase(16'($urandom), 16'($urandom), 50, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
